FILE: rtl/fos_pkg.sv
// Shared types and constants for the Fermi occupancy and slope pipeline.
package fos_pkg;

    typedef struct packed {
        logic limit;
        logic positive;
    } fos_flags_t;

    typedef enum logic {
        REG_TEMPERATURE = 1'b0
    } fos_reg_t;

    localparam logic [31:0] TEMP_RESET   = 32'h0001_0000;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
    localparam logic [31:0] HALF_Q31     = 32'h8000_0000;
    localparam int          HORNER_TERMS = 13;
    localparam int          RECIP_SHIFT  = 36;

    localparam logic [36:0] RECIP [1:HORNER_TERMS] = '{
        37'd68719476736, 37'd34359738368, 37'd22906492245, 37'd17179869184,
        37'd13743895347, 37'd11453246122, 37'd9817068105,  37'd8589934592,
        37'd7635497415,  37'd6871947673,  37'd6247225157,  37'd5726623061,
        37'd5286113595
    };

endpackage

FILE: rtl/fos_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
module fos_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_stream,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quot,
    output logic [DW-1:0] out_rem,
    output logic [SW-1:0] out_side
);

    logic [QW-1:0] valid_reg;
    logic [DW-1:0] rem_reg    [QW];
    logic [QW-1:0] stream_reg [QW];
    logic [QW-1:0] quot_reg   [QW];
    logic [DW-1:0] div_reg    [QW];
    logic [SW-1:0] side_reg   [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic          pv;
        logic [DW-1:0] pr;
        logic [QW-1:0] ps;
        logic [QW-1:0] pq;
        logic [DW-1:0] pd;
        logic [SW-1:0] pside;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quot_next;

        if (i == 0)
        begin : g_first
            assign pv    = in_valid;
            assign pr    = in_rem;
            assign ps    = in_stream;
            assign pq    = '0;
            assign pd    = in_div;
            assign pside = in_side;
        end
        else
        begin : g_next
            assign pv    = valid_reg[i-1];
            assign pr    = rem_reg[i-1];
            assign ps    = stream_reg[i-1];
            assign pq    = quot_reg[i-1];
            assign pd    = div_reg[i-1];
            assign pside = side_reg[i-1];
        end

        assign trial     = {pr, ps[QW-1-i]};
        assign ge        = trial >= {1'b0, pd};
        assign rem_next  = ge ? DW'(trial - {1'b0, pd}) : DW'(trial);
        assign quot_next = pq | (ge ? (QW'(1) << (QW-1-i)) : '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]    <= rem_next;
            stream_reg[i] <= ps;
            quot_reg[i]   <= quot_next;
            div_reg[i]    <= pd;
            side_reg[i]   <= pside;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];
    assign out_rem   = rem_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

FILE: rtl/fos_horner.sv
// Pipelined Horner evaluation of exp(-r) in Q1.32 from r in Q0.32, three stages per term.
module fos_horner import fos_pkg::*; #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [31:0]   in_r,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [32:0]   out_p,
    output logic [SW-1:0] out_side
);

    logic [HORNER_TERMS-1:0] va_reg;
    logic [HORNER_TERMS-1:0] vb_reg;
    logic [HORNER_TERMS-1:0] vc_reg;
    logic [31:0]   ma_reg [HORNER_TERMS];
    logic [31:0]   ra_reg [HORNER_TERMS];
    logic [SW-1:0] sa_reg [HORNER_TERMS];
    logic [31:0]   qb_reg [HORNER_TERMS];
    logic [31:0]   mb_reg [HORNER_TERMS];
    logic [31:0]   rb_reg [HORNER_TERMS];
    logic [SW-1:0] sb_reg [HORNER_TERMS];
    logic [32:0]   tc_reg [HORNER_TERMS];
    logic [31:0]   rc_reg [HORNER_TERMS];
    logic [SW-1:0] sc_reg [HORNER_TERMS];

    for (genvar j = 0; j < HORNER_TERMS; j++)
    begin : g_term
        localparam logic [3:0]  K = 4'(HORNER_TERMS - j);
        localparam logic [36:0] M = RECIP[HORNER_TERMS - j];

        logic          pv;
        logic [32:0]   pt;
        logic [31:0]   pr;
        logic [SW-1:0] pside;
        logic [64:0]   prod_rt;
        logic [68:0]   prod_recip;
        logic [35:0]   prod_k;
        logic [35:0]   rem_k;
        logic [31:0]   q_next;
        logic [32:0]   t_next;

        if (j == 0)
        begin : g_first
            assign pv    = in_valid;
            assign pt    = ONE_Q32;
            assign pr    = in_r;
            assign pside = in_side;
        end
        else
        begin : g_next
            assign pv    = vc_reg[j-1];
            assign pt    = tc_reg[j-1];
            assign pr    = rc_reg[j-1];
            assign pside = sc_reg[j-1];
        end

        assign prod_rt    = 65'(pr) * 65'(pt);
        assign prod_recip = 69'(ma_reg[j]) * 69'(M);
        assign prod_k     = 36'(qb_reg[j]) * 36'(K);
        assign rem_k      = 36'(mb_reg[j]) - prod_k;
        assign q_next     = (rem_k >= 36'(K)) ? qb_reg[j] + 32'd1 : qb_reg[j];
        assign t_next     = ONE_Q32 - {1'b0, q_next};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[j] <= 1'b0;
                vb_reg[j] <= 1'b0;
                vc_reg[j] <= 1'b0;
            end
            else
            begin
                va_reg[j] <= pv;
                vb_reg[j] <= va_reg[j];
                vc_reg[j] <= vb_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            ma_reg[j] <= 32'(prod_rt >> 32);
            ra_reg[j] <= pr;
            sa_reg[j] <= pside;
            qb_reg[j] <= 32'(prod_recip >> RECIP_SHIFT);
            mb_reg[j] <= ma_reg[j];
            rb_reg[j] <= ra_reg[j];
            sb_reg[j] <= sa_reg[j];
            tc_reg[j] <= t_next;
            rc_reg[j] <= rb_reg[j];
            sc_reg[j] <= sb_reg[j];
        end
    end

    assign out_valid = vc_reg[HORNER_TERMS-1];
    assign out_p     = tc_reg[HORNER_TERMS-1];
    assign out_side  = sc_reg[HORNER_TERMS-1];

endmodule

FILE: rtl/fermi_occupancy_and_slope.sv
// Fermi-Dirac occupancy and slope pipeline, top level with APB register port.
// Throughput: one transaction per cycle; busy stays low and results cannot be held off.
// Reset: rst_n clears all valid bits and sets temperature to 1.0 (Q16.16).
module fermi_occupancy_and_slope import fos_pkg::*; #(
    parameter int ARG_LIMIT = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] energy_in,
    output logic        done,
    output logic [31:0] occupancy,
    output logic [31:0] slope,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LIM_W = 32 + $clog2(ARG_LIMIT + 1);
    localparam int N_W   = $clog2(ARG_LIMIT * 3 / 2 + 2);
    localparam int FLG_W = $bits(fos_flags_t);

    logic [31:0] temperature_reg;
    logic [31:0] t_eff;
    fos_reg_t    reg_sel;

    assign reg_sel = fos_reg_t'(paddr[2]);
    assign t_eff   = (temperature_reg == '0) ? 32'd1 : temperature_reg;
    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign prdata  = (reg_sel == REG_TEMPERATURE) ? temperature_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temperature_reg <= TEMP_RESET;
        end
        else if (psel && penable && pwrite && reg_sel == REG_TEMPERATURE)
        begin
            temperature_reg <= pwdata;
        end
    end

    // input stage
    logic [31:0]      a_next;
    logic [LIM_W-1:0] lim;
    fos_flags_t       flags_next;
    logic             in_valid_reg;
    logic [31:0]      a_reg;
    fos_flags_t       flags_reg;

    assign a_next              = energy_in[31] ? 32'(~energy_in + 32'd1) : energy_in;
    assign lim                 = LIM_W'(t_eff) * LIM_W'(ARG_LIMIT);
    assign flags_next.positive = (energy_in != '0) && !energy_in[31];
    assign flags_next.limit    = LIM_W'(a_next) > lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        flags_reg <= flags_next;
    end

    // y = a * 2^32 / T
    logic             y_valid;
    logic [LIM_W-1:0] y_quot;
    logic [FLG_W-1:0] y_side;

    fos_div_pipe #(.DW(32), .QW(LIM_W), .SW(FLG_W)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_rem    (32'(a_reg >> (LIM_W - 32))),
        .in_stream (LIM_W'({a_reg, 32'h0})),
        .in_div    (t_eff),
        .in_side   (flags_reg),
        .out_valid (y_valid),
        .out_quot  (y_quot),
        .out_rem   (),
        .out_side  (y_side)
    );

    // n = y / ln2, r = y mod ln2
    logic             n_valid;
    logic [N_W-1:0]   n_quot;
    logic [31:0]      r_rem;
    logic [FLG_W-1:0] n_side;

    fos_div_pipe #(.DW(32), .QW(N_W), .SW(FLG_W)) u_div_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (y_valid),
        .in_rem    (32'(y_quot >> N_W)),
        .in_stream (N_W'(y_quot)),
        .in_div    (LN2_Q32),
        .in_side   (y_side),
        .out_valid (n_valid),
        .out_quot  (n_quot),
        .out_rem   (r_rem),
        .out_side  (n_side)
    );

    // p = exp(-r)
    logic                 p_valid;
    logic [32:0]          p_val;
    logic [FLG_W+N_W-1:0] p_side;

    fos_horner #(.SW(FLG_W + N_W)) u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_valid),
        .in_r      (r_rem),
        .in_side   ({n_side, n_quot}),
        .out_valid (p_valid),
        .out_p     (p_val),
        .out_side  (p_side)
    );

    // x = p >> n, build 2^63 + d/2 over d = 1 + x
    logic [N_W-1:0] p_n;
    logic [32:0]    x_val;
    logic [33:0]    d_next;
    logic [63:0]    num_next;
    logic           d_valid_reg;
    logic [33:0]    d_reg;
    logic [63:0]    num_reg;
    fos_flags_t     d_flags_reg;

    assign p_n      = p_side[N_W-1:0];
    assign x_val    = (32'(p_n) >= 32'd33) ? '0 : (p_val >> p_n);
    assign d_next   = 34'(ONE_Q32) + 34'(x_val);
    assign num_next = 64'h8000_0000_0000_0000 + 64'(d_next >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        num_reg     <= num_next;
        d_flags_reg <= fos_flags_t'(p_side[FLG_W+N_W-1:N_W]);
    end

    // g = round(2^63 / d)
    logic             g_valid;
    logic [31:0]      g_quot;
    logic [FLG_W-1:0] g_side;

    fos_div_pipe #(.DW(34), .QW(32), .SW(FLG_W)) u_div_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_rem    (34'(num_reg[63:32])),
        .in_stream (num_reg[31:0]),
        .in_div    (d_reg),
        .in_side   (d_flags_reg),
        .out_valid (g_valid),
        .out_quot  (g_quot),
        .out_rem   (),
        .out_side  (g_side)
    );

    // clamp g, form h and occupancy
    logic [31:0] g_clamp;
    logic [31:0] h_next;
    fos_flags_t  g_flags;
    logic        gh_valid_reg;
    logic [31:0] g_reg;
    logic [31:0] h_reg;
    logic [31:0] occ_gh_reg;
    fos_flags_t  gh_flags_reg;

    assign g_flags = fos_flags_t'(g_side);
    assign g_clamp = (g_quot > HALF_Q31) ? HALF_Q31 : g_quot;
    assign h_next  = HALF_Q31 - g_clamp;

    // multiply g*h
    logic        mul_valid_reg;
    logic [63:0] gh_prod_reg;
    logic [31:0] occ_mul_reg;
    fos_flags_t  mul_flags_reg;

    // round term and scale down by 2^30
    logic [63:0] sum_next;
    logic        f_valid_reg;
    logic [31:0] f_reg;
    logic [31:0] occ_f_reg;
    fos_flags_t  f_flags_reg;

    assign sum_next = gh_prod_reg + (64'(t_eff) << 29);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gh_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            f_valid_reg   <= 1'b0;
        end
        else
        begin
            gh_valid_reg  <= g_valid;
            mul_valid_reg <= gh_valid_reg;
            f_valid_reg   <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg         <= g_clamp;
        h_reg         <= h_next;
        occ_gh_reg    <= g_flags.positive ? h_next : g_clamp;
        gh_flags_reg  <= g_flags;
        gh_prod_reg   <= 64'(g_reg) * 64'(h_reg);
        occ_mul_reg   <= occ_gh_reg;
        mul_flags_reg <= gh_flags_reg;
        f_reg         <= 32'(sum_next >> 30);
        occ_f_reg     <= occ_mul_reg;
        f_flags_reg   <= mul_flags_reg;
    end

    // q = F / T
    logic                q_valid;
    logic [31:0]         q_quot;
    logic [FLG_W+31:0]   q_side;

    fos_div_pipe #(.DW(32), .QW(32), .SW(FLG_W + 32)) u_div_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .in_rem    ('0),
        .in_stream (f_reg),
        .in_div    (t_eff),
        .in_side   ({f_flags_reg, occ_f_reg}),
        .out_valid (q_valid),
        .out_quot  (q_quot),
        .out_rem   (),
        .out_side  (q_side)
    );

    // output register
    fos_flags_t  q_flags;
    logic [31:0] q_clamp;
    logic [31:0] occ_next;
    logic [31:0] slope_next;
    logic        done_reg;
    logic [31:0] occupancy_reg;
    logic [31:0] slope_reg;

    assign q_flags    = fos_flags_t'(q_side[FLG_W+31:32]);
    assign q_clamp    = (q_quot > HALF_Q31) ? HALF_Q31 : q_quot;
    assign occ_next   = q_flags.limit ? (q_flags.positive ? '0 : HALF_Q31) : q_side[31:0];
    assign slope_next = q_flags.limit ? '0 : 32'(32'd0 - q_clamp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        occupancy_reg <= occ_next;
        slope_reg     <= slope_next;
    end

    assign done      = done_reg;
    assign occupancy = occupancy_reg;
    assign slope     = slope_reg;

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> occupancy <= HALF_Q31)
        else $error("occupancy above one");

    a_slope_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (slope[31] || slope == '0))
        else $error("slope positive");

    a_slope_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (done && slope != '0) |-> (occupancy != '0 && occupancy != HALF_Q31))
        else $error("nonzero slope at saturated occupancy");

endmodule

FILE: test/testbench.sv
// Testbench for the Fermi occupancy and slope pipeline: directed and random checks.
module testbench;
    import fos_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ARG_LIMIT     = 40;
    localparam int          LATENCY       = 160;
    localparam logic [2:0]  ADDR_TEMP     = {REG_TEMPERATURE, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;
    localparam logic [63:0] UNIT_Q32      = 64'h1_0000_0000;
    localparam logic [63:0] LN2_CONST     = 64'd2977044472;
    localparam logic [63:0] HALF_CONST    = 64'h8000_0000;

    typedef struct packed {
        logic [31:0] occ;
        logic [31:0] slp;
    } fermi_t;

    typedef struct {
        logic [31:0] energy;
        bit          typed;
        logic [31:0] occ;
        logic [31:0] slp;
    } vector_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] energy_in = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        done;
    logic [31:0] occupancy;
    logic [31:0] slope;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] temp_model = TEMP_RESET;
    fermi_t      pending_fermi[$];
    int          mismatches = 0;

    fermi_occupancy_and_slope dut (.*);

    always #5 clk = ~clk;

    function automatic fermi_t fermi_predict(logic [31:0] e, logic [31:0] temp);
        bit [63:0] a, t, lim, y, n, r, x, m, d, g, h, dv, q;
        bit        pos, neg;
        logic [31:0] mag;
        fermi_t    res;
        neg = e[31];
        pos = !neg && (e != 0);
        mag = neg ? (~e + 32'd1) : e;
        a = {32'b0, mag};
        t = (temp == 0) ? 64'd1 : {32'b0, temp};
        lim = ARG_LIMIT * t;
        if (a > lim)
        begin
            res.occ = pos ? 32'd0 : HALF_CONST[31:0];
            res.slp = 32'd0;
            return res;
        end
        y = (a << 32) / t;
        n = y / LN2_CONST;
        r = y - n * LN2_CONST;
        x = UNIT_Q32;
        for (int k = 13; k >= 1; k--)
        begin
            m = (r * x) >> 32;
            x = UNIT_Q32 - m / k;
        end
        x = (n >= 33) ? 64'd0 : (x >> n);
        d = UNIT_Q32 + x;
        g = ((64'd1 << 63) + (d >> 1)) / d;
        if (g > HALF_CONST)
            g = HALF_CONST;
        h = HALF_CONST - g;
        dv = t << 30;
        q = (g * h + (dv >> 1)) / dv;
        if (q > HALF_CONST)
            q = HALF_CONST;
        res.occ = pos ? h[31:0] : g[31:0];
        res.slp = 32'd0 - q[31:0];
        return res;
    endfunction

    task automatic send_energy(vector_t v);
        fermi_t f;
        start <= 1'b1;
        energy_in <= v.energy;
        do
            @(posedge clk);
        while (busy);
        f = fermi_predict(v.energy, temp_model);
        if (v.typed)
        begin
            f.occ = v.occ;
            f.slp = v.slp;
        end
        pending_fermi.push_back(f);
    endtask

    task automatic pause_sender();
        start <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending_fermi.size() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_TEMP)
            temp_model = value;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_energy(logic [31:0] temp);
        bit [63:0]   lim;
        logic [31:0] mag;
        lim = ARG_LIMIT * ((temp == 0) ? 64'd1 : {32'b0, temp});
        if (lim > HALF_CONST)
            lim = HALF_CONST;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: mag = $urandom_range(0, lim[31:0]);
            2: mag = $urandom_range(0, (lim[31:0] >> 4) + 1);
            default: mag = lim[31:0] + $urandom_range(0, 2) - 1;
        endcase
        return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
    endfunction

    always @(posedge clk)
    begin
        fermi_t want;
        if (rst_n && done)
        begin
            if (pending_fermi.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: occ %h slope %h", occupancy, slope);
            end
            else
            begin
                want = pending_fermi.pop_front();
                if (occupancy !== want.occ || slope !== want.slp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected occ %h slope %h, got occ %h slope %h",
                                 want.occ, want.slp, occupancy, slope);
                end
            end
        end
    end

    initial
    begin
        vector_t     directed[$];
        vector_t     v;
        logic [31:0] temps[$];
        int          burst;
        int          left;
        directed = '{
            '{32'h7fff_ffff, 1'b1, 32'h0000_0000, 32'h0000_0000},
            '{32'h8000_0000, 1'b1, 32'h8000_0000, 32'h0000_0000},
            '{32'h0000_0000, 1'b1, 32'h4000_0000, 32'hffff_c000},
            '{32'h0028_0000, 1'b0, 32'h0, 32'h0},
            '{32'h0028_0001, 1'b1, 32'h0000_0000, 32'h0000_0000},
            '{32'hffd8_0000, 1'b0, 32'h0, 32'h0},
            '{32'hffd7_ffff, 1'b1, 32'h8000_0000, 32'h0000_0000},
            '{32'h0000_0001, 1'b0, 32'h0, 32'h0},
            '{32'hffff_ffff, 1'b0, 32'h0, 32'h0},
            '{32'h0001_0000, 1'b0, 32'h0, 32'h0},
            '{32'hffff_0000, 1'b0, 32'h0, 32'h0},
            '{32'h000b_1721, 1'b0, 32'h0, 32'h0},
            '{32'h0016_2e43, 1'b0, 32'h0, 32'h0},
            '{32'h0017_0000, 1'b0, 32'h0, 32'h0},
            '{32'h0000_8000, 1'b0, 32'h0, 32'h0},
            '{32'hfff8_0000, 1'b0, 32'h0, 32'h0}
        };
        temps = '{32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 32'h0000_8000,
                  32'h0001_0000, $urandom(), $urandom_range(1, 32'h0010_0000),
                  $urandom_range(32'h0100_0000, 32'h0fff_ffff)};
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            send_energy(directed[i]);
            if ($urandom_range(0, 3) == 0)
                pause_sender();
        end
        drain_pipeline();
        write_reg(ADDR_UNMAPPED, 32'h0000_0002);
        foreach (temps[j])
        begin
            drain_pipeline();
            write_reg(ADDR_TEMP, temps[j]);
            left = 225;
            while (left > 0)
            begin
                burst = $urandom_range(1, 40);
                while (burst > 0 && left > 0)
                begin
                    v = '{random_energy(temp_model), 1'b0, 32'h0, 32'h0};
                    send_energy(v);
                    burst--;
                    left--;
                end
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
        end
        drain_pipeline();
        if (mismatches == 0 && pending_fermi.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule
